FILE: design/nlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlt_pkg: shared types and constants for the neighbor liveness table
// table depth, field widths, result codes and controller/datapath links
// ----------------------------------------------------------------------------
package nlt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	localparam int IP_W       = 32;
	localparam int TIMER_W    = 16;
	localparam int SEQ_W      = 32;
	localparam int STATUS_W   = 3;
	localparam int ENTRY_W    = 4;
	localparam int TOTAL_W    = 5;
	localparam int DEATHS_W   = 5;

	localparam logic [TIMER_W-1:0] DECAY_RESET = TIMER_W'(8);

	// item kinds
	localparam logic FUNC_HELLO = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_REFRESHED  = 3'd0,
		ST_ADDED      = 3'd1,
		ST_FULL       = 3'd2,
		ST_TICK_QUIET = 3'd3,
		ST_TICK_DEATH = 3'd4
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_WALK = 1'b1
	} ctrl_state_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture transaction fields, restart walk
		logic issue;    // read table entry at walk pointer
		logic compact;  // age the entry read last cycle, keep it if alive
		logic refresh;  // reload timer of the matching entry, give result
		logic finish;   // append / drop / commit aging, give result
	} nlt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic more;     // walk pointer below neighbor count
		logic pending;  // an entry read is waiting to be evaluated
		logic hit;      // pending entry matches the hello address
		logic is_tick;  // captured item is an aging tick
	} nlt_stat_t;

endpackage

FILE: design/nlt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlt_ctrl: controller for the neighbor liveness table
// sequences the table walk and picks the finishing action
// ----------------------------------------------------------------------------
module nlt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  nlt_pkg::nlt_stat_t stat,
	output nlt_pkg::nlt_cmd_t  cmd,
	output logic              busy
);
	import nlt_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_WALK;
				end
			end
			S_WALK: begin
				if (!stat.is_tick && stat.hit) begin
					// known neighbor, stop the walk here
					cmd.refresh = 1'b1;
					state_d     = S_IDLE;
				end else if (!stat.more && !stat.pending) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.issue   = stat.more;
					cmd.compact = stat.is_tick && stat.pending;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

FILE: design/nlt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlt_datapath: table storage, walk pointers and result registers
// one table read per cycle, one write per cycle, registered results
// ----------------------------------------------------------------------------
module nlt_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  nlt_pkg::nlt_cmd_t                 cmd,
	output nlt_pkg::nlt_stat_t                stat,
	input  logic                              func,
	input  logic [nlt_pkg::IP_W-1:0]          neighbor_ip,
	input  logic [nlt_pkg::TIMER_W-1:0]       dead_interval,
	input  logic                              cfg_we,
	input  logic [nlt_pkg::TIMER_W-1:0]       cfg_wdata,
	output logic                              done,
	output logic [nlt_pkg::STATUS_W-1:0]      status,
	output logic [nlt_pkg::ENTRY_W-1:0]       entry_index,
	output logic [nlt_pkg::TOTAL_W-1:0]       neighbor_total,
	output logic [nlt_pkg::DEATHS_W-1:0]      deaths,
	output logic [nlt_pkg::SEQ_W-1:0]         advert_sequence,
	output logic                              advert_changed
);
	import nlt_pkg::*;

	logic [IP_W-1:0]    addr_mem  [TABLE_DEPTH];
	logic [TIMER_W-1:0] timer_mem [TABLE_DEPTH];

	logic               func_q;
	logic [IP_W-1:0]    ip_q;
	logic [TIMER_W-1:0] reload_q;
	logic [TIMER_W-1:0] decay_q;
	logic [CNT_W-1:0]   count_q;
	logic [SEQ_W-1:0]   seq_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic [CNT_W-1:0]   kept_q;

	logic               valid_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [IP_W-1:0]    addr_s1;
	logic [TIMER_W-1:0] timer_s1;

	logic               done_q;
	status_t            status_q;
	logic [ENTRY_W-1:0] entry_q;
	logic [DEATHS_W-1:0] deaths_q;
	logic               changed_q;

	logic [TIMER_W-1:0] aged;
	logic               alive;
	logic               full;
	logic [CNT_W-1:0]   dead_cnt;

	logic               wr_en;
	logic               wr_addr_en;
	logic [IDX_W-1:0]   wr_idx;
	logic [IP_W-1:0]    wr_addr;
	logic [TIMER_W-1:0] wr_timer;

	// saturating decay of the entry read last cycle
	assign aged     = (timer_s1 > decay_q) ? (timer_s1 - decay_q) : '0;
	assign alive    = (aged != '0);
	assign full     = (count_q >= CNT_W'(TABLE_DEPTH));
	assign dead_cnt = count_q - kept_q;

	assign stat.more    = (rd_idx_q < count_q);
	assign stat.pending = valid_s1;
	assign stat.hit     = valid_s1 && (addr_s1 == ip_q);
	assign stat.is_tick = (func_q == FUNC_TICK);

	always_comb begin
		wr_en      = 1'b0;
		wr_addr_en = 1'b0;
		wr_idx     = idx_s1;
		wr_addr    = addr_s1;
		wr_timer   = reload_q;
		if (cmd.refresh) begin
			wr_en = 1'b1;
		end else if (cmd.compact && alive) begin
			wr_en      = 1'b1;
			wr_addr_en = 1'b1;
			wr_idx     = kept_q[IDX_W-1:0];
			wr_timer   = aged;
		end else if (cmd.finish && !stat.is_tick && !full) begin
			wr_en      = 1'b1;
			wr_addr_en = 1'b1;
			wr_idx     = count_q[IDX_W-1:0];
			wr_addr    = ip_q;
		end
	end

	// table storage
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			addr_s1  <= addr_mem[rd_idx_q[IDX_W-1:0]];
			timer_s1 <= timer_mem[rd_idx_q[IDX_W-1:0]];
		end
		if (wr_en) begin
			timer_mem[wr_idx] <= wr_timer;
		end
		if (wr_addr_en) begin
			addr_mem[wr_idx] <= wr_addr;
		end
	end

	// captured fields and result payload
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (cmd.load) begin
			func_q   <= func;
			ip_q     <= neighbor_ip;
			reload_q <= dead_interval;
		end
		if (cmd.refresh) begin
			status_q  <= ST_REFRESHED;
			entry_q   <= ENTRY_W'(idx_s1);
			deaths_q  <= '0;
			changed_q <= 1'b0;
		end else if (cmd.finish) begin
			entry_q  <= '0;
			deaths_q <= '0;
			if (stat.is_tick) begin
				deaths_q  <= DEATHS_W'(dead_cnt);
				changed_q <= (dead_cnt != '0);
				status_q  <= (dead_cnt != '0) ? ST_TICK_DEATH : ST_TICK_QUIET;
			end else if (full) begin
				status_q  <= ST_FULL;
				changed_q <= 1'b0;
			end else begin
				status_q  <= ST_ADDED;
				entry_q   <= ENTRY_W'(count_q);
				changed_q <= 1'b1;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q  <= DECAY_RESET;
			count_q  <= '0;
			seq_q    <= '0;
			rd_idx_q <= '0;
			kept_q   <= '0;
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				decay_q <= cfg_wdata;
			end
			valid_s1 <= cmd.issue;
			done_q   <= cmd.refresh || cmd.finish;
			if (cmd.load) begin
				rd_idx_q <= '0;
				kept_q   <= '0;
			end else begin
				if (cmd.issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (cmd.compact && alive) begin
					kept_q <= kept_q + 1'b1;
				end
			end
			if (cmd.finish) begin
				if (stat.is_tick) begin
					count_q <= kept_q;
					if (dead_cnt != '0) begin
						seq_q <= seq_q + 1'b1;
					end
				end else if (!full) begin
					count_q <= count_q + 1'b1;
					seq_q   <= seq_q + 1'b1;
				end
			end
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign entry_index     = entry_q;
	assign neighbor_total  = TOTAL_W'(count_q);
	assign deaths          = deaths_q;
	assign advert_sequence = seq_q;
	assign advert_changed  = changed_q;

endmodule

FILE: design/neighbor_liveness_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// neighbor_liveness_table: neighbor table with dead timers
// hello lookup / append and aging tick with order-preserving compaction
// ----------------------------------------------------------------------------
//
// channel   handshake           payload
// -------   -----------------   ------------------------------------------
// command   start / busy        func, neighbor_ip, dead_interval
// result    done (one cycle)    status, entry_index, neighbor_total,
//                               deaths, advert_sequence, advert_changed
// config    cfg_we              cfg_wdata (decay step)
//
// a transaction walks the neighbors held, reading one table entry per cycle
// through the single table read port, each read registered before it is
// evaluated; a hello that matches ends early at its matching entry.
// reset clears neighbor count, sequence and result strobe, and loads the
// decay step with 8; table contents need no reset
// busy is high from the accepting edge until the edge that raises done, so
// a new start may be given while done is high; the receiver cannot stall
//
module neighbor_liveness_table (
	input  logic                           clk,
	input  logic                           arst_n,
	// command channel
	input  logic                           start,
	output logic                           busy,
	input  logic                           func,
	input  logic [nlt_pkg::IP_W-1:0]       neighbor_ip,
	input  logic [nlt_pkg::TIMER_W-1:0]    dead_interval,
	// configuration
	input  logic                           cfg_we,
	input  logic [nlt_pkg::TIMER_W-1:0]    cfg_wdata,
	// result channel
	output logic                           done,
	output logic [nlt_pkg::STATUS_W-1:0]   status,
	output logic [nlt_pkg::ENTRY_W-1:0]    entry_index,
	output logic [nlt_pkg::TOTAL_W-1:0]    neighbor_total,
	output logic [nlt_pkg::DEATHS_W-1:0]   deaths,
	output logic [nlt_pkg::SEQ_W-1:0]      advert_sequence,
	output logic                           advert_changed
);
	import nlt_pkg::*;

	nlt_cmd_t  cmd;
	nlt_stat_t stat;
	logic      ctrl_busy;

	// controller only sees start while idle, so gating is done by its state
	nlt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (ctrl_busy)
	);

	// table, walk pointers, sequence number and result registers
	nlt_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.func            (func),
		.neighbor_ip     (neighbor_ip),
		.dead_interval   (dead_interval),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.done            (done),
		.status          (status),
		.entry_index     (entry_index),
		.neighbor_total  (neighbor_total),
		.deaths          (deaths),
		.advert_sequence (advert_sequence),
		.advert_changed  (advert_changed)
	);

	assign busy = ctrl_busy;

endmodule

FILE: design/nlt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlt_checker: port-level checks for the neighbor liveness table
// watches command and result ports over time
// ----------------------------------------------------------------------------
module nlt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [nlt_pkg::STATUS_W-1:0]  status,
	input logic [nlt_pkg::ENTRY_W-1:0]   entry_index,
	input logic [nlt_pkg::DEATHS_W-1:0]  deaths,
	input logic                          advert_changed
);
	import nlt_pkg::*;

	// an accepted transaction always occupies the block
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// a result arrives only when the block has gone idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// one result per transaction, never on back-to-back cycles
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	// sequence bump only for an added neighbor or a tick with deaths
	a_changed: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (advert_changed == ((status == ST_ADDED) || (status == ST_TICK_DEATH))))
		else $error("advert_changed does not match status");

	// ticks and dropped hellos report no slot, and only a tick with deaths reports deaths
	a_tick_fields: assert property (@(posedge clk) disable iff (!arst_n)
		done && ((status == ST_TICK_QUIET) || (status == ST_TICK_DEATH)
		|| (status == ST_FULL)) |-> (entry_index == '0)
		&& ((deaths != '0) == (status == ST_TICK_DEATH)))
		else $error("slot or death count inconsistent with status");

endmodule

bind neighbor_liveness_table nlt_checker u_nlt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.status         (status),
	.entry_index    (entry_index),
	.deaths         (deaths),
	.advert_changed (advert_changed)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the neighbor liveness table
// drives hello and aging-tick commands through start / busy, predicts each
// result with a cycle-free model of the table and dead timers, and compares
// every done strobe field by field against the oldest prediction; the decay
// step is reprogrammed between phases whenever the block has gone quiet
// ----------------------------------------------------------------------------
module tb_top;
	import nlt_pkg::*;

	// one predicted or observed result transaction
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ENTRY_W-1:0]  entry_index;
		logic [TOTAL_W-1:0]  neighbor_total;
		logic [DEATHS_W-1:0] deaths;
		logic [SEQ_W-1:0]    advert_sequence;
		logic                advert_changed;
	} liveness_result_t;

	// table model plus queue of results still owed by the block
	class liveness_scoreboard;
		logic [IP_W-1:0]    peer_ip [TABLE_DEPTH];
		logic [TIMER_W-1:0] peer_life [TABLE_DEPTH];
		int unsigned        peer_cnt;
		logic [SEQ_W-1:0]   advert_seq;
		logic [TIMER_W-1:0] decay_step;
		liveness_result_t   owed_results [$];
		int unsigned        mismatches;

		function new();
			peer_cnt   = 0;
			advert_seq = '0;
			decay_step = DECAY_RESET;
			mismatches = 0;
		endfunction

		function void set_decay(logic [TIMER_W-1:0] value);
			decay_step = value;
		endfunction

		function int unsigned pending();
			return owed_results.size();
		endfunction

		// an accepted command: update the table model and queue its result
		function void record_command(logic kind, logic [IP_W-1:0] ip,
				logic [TIMER_W-1:0] reload);
			liveness_result_t   r;
			bit                 hit;
			int unsigned        kept;
			logic [TIMER_W-1:0] aged;
			r   = '0;
			hit = 1'b0;
			if (kind == FUNC_HELLO) begin
				for (int i = 0; i < peer_cnt; i++) begin
					if (!hit && peer_ip[i] == ip) begin
						peer_life[i]  = reload;
						r.status      = ST_REFRESHED;
						r.entry_index = ENTRY_W'(i);
						hit           = 1'b1;
					end
				end
				if (!hit) begin
					if (peer_cnt >= TABLE_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						peer_ip[peer_cnt]   = ip;
						peer_life[peer_cnt] = reload;
						r.status            = ST_ADDED;
						r.entry_index       = ENTRY_W'(peer_cnt);
						r.advert_changed    = 1'b1;
						peer_cnt++;
						advert_seq++;
					end
				end
			end else begin
				kept = 0;
				for (int i = 0; i < peer_cnt; i++) begin
					aged = (peer_life[i] > decay_step) ? peer_life[i] - decay_step : '0;
					if (aged != 0) begin
						peer_ip[kept]   = peer_ip[i];
						peer_life[kept] = aged;
						kept++;
					end
				end
				if (kept != peer_cnt) begin
					r.status         = ST_TICK_DEATH;
					r.deaths         = DEATHS_W'(peer_cnt - kept);
					r.advert_changed = 1'b1;
					advert_seq++;
				end else begin
					r.status = ST_TICK_QUIET;
				end
				peer_cnt = kept;
			end
			r.neighbor_total  = TOTAL_W'(peer_cnt);
			r.advert_sequence = advert_seq;
			owed_results.push_back(r);
		endfunction

		// a done strobe: compare against the oldest owed result
		function void check_result(liveness_result_t got);
			liveness_result_t want;
			if (owed_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] result with no transaction outstanding", $realtime);
				return;
			end
			want = owed_results.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] result mismatch (expected/actual): status %0d/%0d index %0d/%0d",
						$realtime, want.status, got.status,
						want.entry_index, got.entry_index);
					$display("  total %0d/%0d deaths %0d/%0d seq %h/%h changed %0d/%0d",
						want.neighbor_total, got.neighbor_total, want.deaths, got.deaths,
						want.advert_sequence, got.advert_sequence,
						want.advert_changed, got.advert_changed);
				end
			end
		endfunction
	endclass

	// every block input starts at a known value
	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                start         = 1'b0;
	logic                func          = FUNC_HELLO;
	logic [IP_W-1:0]     neighbor_ip   = '0;
	logic [TIMER_W-1:0]  dead_interval = '0;
	logic                cfg_we        = 1'b0;
	logic [TIMER_W-1:0]  cfg_wdata     = '0;
	logic                busy;
	logic                done;
	logic [STATUS_W-1:0] status;
	logic [ENTRY_W-1:0]  entry_index;
	logic [TOTAL_W-1:0]  neighbor_total;
	logic [DEATHS_W-1:0] deaths;
	logic [SEQ_W-1:0]    advert_sequence;
	logic                advert_changed;

	liveness_scoreboard sb = new();

	neighbor_liveness_table uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.neighbor_ip     (neighbor_ip),
		.dead_interval   (dead_interval),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.done            (done),
		.status          (status),
		.entry_index     (entry_index),
		.neighbor_total  (neighbor_total),
		.deaths          (deaths),
		.advert_sequence (advert_sequence),
		.advert_changed  (advert_changed)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// result side: the receiver never stalls, so every done cycle is a transaction;
	// outputs are read at the edge before the block's own updates land
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result('{status, entry_index, neighbor_total, deaths,
				advert_sequence, advert_changed});
	end

	// hold start with the command fields until an edge sees busy low; start is
	// left high so the caller can chain the next command without a bubble
	task automatic send_command(logic kind, logic [IP_W-1:0] ip,
			logic [TIMER_W-1:0] reload);
		start         <= 1'b1;
		func          <= kind;
		neighbor_ip   <= ip;
		dead_interval <= reload;
		do
			@(posedge clk);
		while (busy);
		sb.record_command(kind, ip, reload);
	endtask

	// sender idle burst
	task automatic sender_pause(int unsigned cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// wait until every owed result has come back; checked on the falling edge
	// so the answer never depends on the monitor running first
	task automatic drain();
		start <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending() != 0);
		@(posedge clk);
	endtask

	// only called with the block idle
	task automatic load_decay_step(logic [TIMER_W-1:0] value);
		cfg_wdata <= value;
		cfg_we    <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_decay(value);
	endtask

	// random traffic: hellos mostly drawn from a small address pool so entries get
	// refreshed and the table can fill, reload values scaled to the decay step so
	// entries live a few ticks, and ticks at a per-phase rate
	task automatic run_aging_phase(int unsigned items, bit calm);
		logic [IP_W-1:0]    pool [$];
		logic [IP_W-1:0]    ip;
		logic [TIMER_W-1:0] reload;
		int unsigned        pool_size;
		int unsigned        tick_odds;
		int unsigned        gap_odds;
		int unsigned        life;
		pool_size = $urandom_range(17, 28);
		tick_odds = $urandom_range(3, 10);
		gap_odds  = 0;
		for (int n = 0; n < pool_size; n++)
			pool.push_back($urandom);
		for (int n = 0; n < items; n++) begin
			// idle pattern changes every 40 transactions, zero meaning none
			if (n % 40 == 0)
				gap_odds = calm ? 0 : $urandom_range(0, 4);
			if ($urandom_range(1, tick_odds) == 1) begin
				// address and reload are don't-care on a tick; keep them toggling
				send_command(FUNC_TICK, $urandom, TIMER_W'($urandom));
			end else begin
				ip = ($urandom_range(0, 3) == 0) ? $urandom : pool[$urandom_range(0, pool_size - 1)];
				case ($urandom_range(0, 9))
					0: reload = '0;
					1: reload = '1;
					2, 3: reload = TIMER_W'($urandom);
					default: begin
						if (sb.decay_step == 0)
							life = $urandom_range(1, 300);
						else
							life = sb.decay_step * $urandom_range(1, 8) + $urandom_range(0, 1);
						reload = (life > 65535) ? '1 : TIMER_W'(life);
					end
				endcase
				send_command(FUNC_HELLO, ip, reload);
			end
			if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
				sender_pause($urandom_range(1, 15));
		end
	endtask

	initial begin
		logic [TIMER_W-1:0] phase_decay [8];
		phase_decay = '{TIMER_W'(8), TIMER_W'(1), TIMER_W'(65535), TIMER_W'(0),
			TIMER_W'($urandom_range(2, 60)), TIMER_W'($urandom_range(1, 65535)),
			TIMER_W'($urandom_range(2, 24)), TIMER_W'(8)};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed part, decay step at its reset value of 8 ---
		// tick on an empty table
		send_command(FUNC_TICK, '0, '0);
		// all-zero address with a zero dead interval, dies on the next tick
		send_command(FUNC_HELLO, '0, '0);
		// all-ones address and reload, then the same address again is a refresh
		send_command(FUNC_HELLO, '1, '1);
		send_command(FUNC_HELLO, '1, '1);
		// timer below the decay step saturates to zero
		send_command(FUNC_HELLO, 32'h5A5A_A5A5, 16'd3);
		send_command(FUNC_TICK, '1, '1);
		// fill the table, then a new address must be dropped
		for (int k = 1; k <= 15; k++)
			send_command(FUNC_HELLO, 32'h0101_0101 * k, 16'h8000);
		send_command(FUNC_HELLO, 32'hA5A5_5A5A, 16'h1234);
		// refresh with zero in a full table, then a tick removes just that slot
		send_command(FUNC_HELLO, '1, '0);
		send_command(FUNC_TICK, '0, '0);
		// zero decay step: timers hold, but a zero timer still goes
		drain();
		load_decay_step('0);
		send_command(FUNC_HELLO, 32'h0303_0303, '0);
		send_command(FUNC_TICK, '0, '0);
		// largest decay step wipes the whole table
		drain();
		load_decay_step('1);
		send_command(FUNC_TICK, '0, '0);

		// --- random phases, one decay step each; the last runs with no idling ---
		for (int p = 0; p < 8; p++) begin
			drain();
			load_decay_step(phase_decay[p]);
			run_aging_phase(228, p == 7);
		end

		drain();
		repeat (25) @(posedge clk);
		if (sb.mismatches + sb.pending() == 0)
			$display("neighbor_liveness_table verification clean");
		else
			$display("neighbor_liveness_table verification failed");
		$finish;
	end

	// watchdog, several times the slowest legal run
	initial begin
		#5_000_000;
		$display("neighbor_liveness_table verification failed");
		$finish;
	end

endmodule
